[rtl/core/salc_pkg.sv]
`default_nettype none
package salc_pkg;

   localparam int ADDR_W     = 32;
   localparam int CNT_W      = 32;
   localparam int SETCFG_W   = 5;
   localparam int WAYCFG_W   = 3;
   localparam int WAYOUT_W   = 2;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAY_COUNT = 1'b1;

   localparam logic [SETCFG_W-1:0] SET_COUNT_RESET = 5'd16;
   localparam logic [WAYCFG_W-1:0] WAY_COUNT_RESET = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_META,
      ST_TAG_RD,
      ST_TAG_CMP,
      ST_UPDATE
   } state_type;

endpackage
`default_nettype wire

[rtl/core/set_assoc_lru_cache_lookup_top.sv]
`default_nettype none
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: address[31:0]
// rsp     | out | rsp_tvalid/tready    | tdata: way_used, evicted_valid, evicted_address,
//         |     |                      |        hit_total, miss_total; tuser: hit
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
// A request finds its set as the address modulo the configured set count, using the
// bit-serial set-select remainder, then does one tag read and compare per way in
// use over the single-port tag memory; a hit ends the scan.
// After reset a clearing pass over all SETS sets initializes valid and LRU state;
// req_tready stays low meanwhile. One request is in flight at a time; a new one
// is accepted while the last response waits in the output register.
module set_assoc_lru_cache_lookup_top #(
   parameter int SETS      = 16,
   parameter int WAYS      = 4,
   parameter int ADDR_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [salc_pkg::ADDR_W-1:0]          req_tdata,   // address[31:0]
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // way_used[1:0], evicted_valid[2], evicted_address[34:3], hit_total[66:35],
   // miss_total[98:67], zero pad[103:99]
   output logic [salc_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tuser,   // hit
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [salc_pkg::SETCFG_W-1:0]        csr_data
);

   localparam int TAG_W   = (ADDR_BITS < salc_pkg::ADDR_W) ? ADDR_BITS : salc_pkg::ADDR_W;
   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINES   = SETS * WAYS;
   localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int SET_CAP = (SETS < 31) ? SETS : 31;
   localparam int WAY_CAP = (WAYS < 7) ? WAYS : 7;

   typedef struct packed {
      logic [WAYS-1:0]            valid;
      logic [WAYS-1:0][WAY_W-1:0] rank;
   } meta_type;

   salc_pkg::state_type state_ff, state_in;

   logic [salc_pkg::SETCFG_W-1:0] set_count_ff, set_count_in;
   logic [salc_pkg::WAYCFG_W-1:0] way_count_ff, way_count_in;
   logic [salc_pkg::SETCFG_W-1:0] nsets;
   logic [salc_pkg::WAYCFG_W-1:0] nways;

   logic [TAG_W-1:0]  addr_ff;
   logic [WAY_W-1:0]  last_way_ff;
   logic [SET_W-1:0]  set_ff;
   logic [SET_W-1:0]  clr_ff;
   logic [WAY_W-1:0]  way_ff;

   logic              hit_ff;
   logic [WAY_W-1:0]  hit_way_ff;
   logic              free_ff;
   logic [WAY_W-1:0]  free_way_ff;
   logic [WAY_W-1:0]  best_rank_ff;
   logic [WAY_W-1:0]  best_way_ff;
   logic [TAG_W-1:0]  best_tag_ff;

   logic [salc_pkg::CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [salc_pkg::CNT_W-1:0] miss_cnt_ff, miss_cnt_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [salc_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_user_ff;

   meta_type         meta_mem [SETS];
   logic [TAG_W-1:0] tag_mem [LINES];
   meta_type         meta_q_ff;
   logic [TAG_W-1:0] tag_q_ff;

   logic                      div_done;
   logic [salc_pkg::SETCFG_W-1:0] div_rem;

   logic              div_start;
   logic              load_rsp;
   logic              meta_we;
   logic              tag_we;
   logic [SET_W-1:0]  meta_waddr;
   meta_type          meta_wdata;
   meta_type          meta_clr;
   meta_type          meta_upd;
   logic [LINE_W-1:0] line_idx;
   logic              tag_match;
   logic              rank_better;
   logic [WAY_W-1:0]  chosen;
   logic [WAY_W-1:0]  touch_rank;
   logic              evict;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      set_count_in = set_count_ff;
      way_count_in = way_count_ff;
      if (csr_valid) begin
         case (csr_index)
            salc_pkg::CSR_SET_COUNT: set_count_in = csr_data;
            salc_pkg::CSR_WAY_COUNT: way_count_in = csr_data[salc_pkg::WAYCFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (set_count_ff == '0) begin
         nsets = salc_pkg::SETCFG_W'(1);
      end else if (set_count_ff > salc_pkg::SETCFG_W'(SET_CAP)) begin
         nsets = salc_pkg::SETCFG_W'(SET_CAP);
      end else begin
         nsets = set_count_ff;
      end
      if (way_count_ff == '0) begin
         nways = salc_pkg::WAYCFG_W'(1);
      end else if (way_count_ff > salc_pkg::WAYCFG_W'(WAY_CAP)) begin
         nways = salc_pkg::WAYCFG_W'(WAY_CAP);
      end else begin
         nways = way_count_ff;
      end
   end

   salc_rem #(
      .DIVIDEND_W (TAG_W),
      .DIVISOR_W  (salc_pkg::SETCFG_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata[TAG_W-1:0]),
      .divisor   (nsets),
      .done      (div_done),
      .remainder (div_rem)
   );

   // datapath helpers
   assign line_idx    = LINE_W'(LINE_W'(set_ff) * LINE_W'(WAYS) + LINE_W'(way_ff));
   assign tag_match   = meta_q_ff.valid[way_ff] && (tag_q_ff == addr_ff);
   assign rank_better = (way_ff == '0) || (meta_q_ff.rank[way_ff] > best_rank_ff);

   always_comb begin
      if (hit_ff) begin
         chosen = hit_way_ff;
      end else if (free_ff) begin
         chosen = free_way_ff;
      end else begin
         chosen = best_way_ff;
      end
      evict      = !hit_ff && !free_ff;
      touch_rank = meta_q_ff.rank[chosen];
      meta_upd   = meta_q_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (meta_q_ff.rank[w] < touch_rank) begin
            meta_upd.rank[w] = meta_q_ff.rank[w] + WAY_W'(1);
         end
         meta_clr.rank[w] = WAY_W'(w);
      end
      meta_upd.rank[chosen]  = '0;
      meta_upd.valid[chosen] = 1'b1;
      meta_clr.valid         = '0;
   end

   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (hit_ff) begin
         if (hit_cnt_ff != '1) begin
            hit_cnt_in = hit_cnt_ff + salc_pkg::CNT_W'(1);
         end
      end else if (miss_cnt_ff != '1) begin
         miss_cnt_in = miss_cnt_ff + salc_pkg::CNT_W'(1);
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         salc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = salc_pkg::ST_DIV;
            end
         end
         salc_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = salc_pkg::ST_META;
            end
         end
         salc_pkg::ST_META:   state_in = salc_pkg::ST_TAG_RD;
         salc_pkg::ST_TAG_RD: state_in = salc_pkg::ST_TAG_CMP;
         salc_pkg::ST_TAG_CMP: begin
            if (tag_match || way_ff == last_way_ff) begin
               state_in = salc_pkg::ST_UPDATE;
            end else begin
               state_in = salc_pkg::ST_TAG_RD;
            end
         end
         salc_pkg::ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         default: state_in = salc_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      load_rsp   = 1'b0;
      meta_we    = 1'b0;
      tag_we     = 1'b0;
      meta_waddr = set_ff;
      meta_wdata = meta_upd;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = meta_clr;
         end
         salc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid;
         end
         salc_pkg::ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               meta_we  = 1'b1;
               tag_we   = !hit_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         set_count_ff <= salc_pkg::SET_COUNT_RESET;
         way_count_ff <= salc_pkg::WAY_COUNT_RESET;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         set_count_ff <= set_count_in;
         way_count_ff <= way_count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == salc_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + SET_W'(1);
         end
         if (load_rsp) begin
            hit_cnt_ff  <= hit_cnt_in;
            miss_cnt_ff <= miss_cnt_in;
         end
      end
   end

   // request datapath
   always_ff @(posedge clock) begin
      if (div_start) begin
         addr_ff     <= req_tdata[TAG_W-1:0];
         last_way_ff <= WAY_W'(nways - salc_pkg::WAYCFG_W'(1));
      end
      if (state_ff == salc_pkg::ST_DIV && div_done) begin
         set_ff <= SET_W'(div_rem);
      end
      if (state_ff == salc_pkg::ST_META) begin
         way_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end
      if (state_ff == salc_pkg::ST_TAG_CMP) begin
         way_ff <= way_ff + WAY_W'(1);
         if (tag_match) begin
            hit_ff     <= 1'b1;
            hit_way_ff <= way_ff;
         end
         if (!meta_q_ff.valid[way_ff] && !free_ff) begin
            free_ff     <= 1'b1;
            free_way_ff <= way_ff;
         end
         if (rank_better) begin
            best_rank_ff <= meta_q_ff.rank[way_ff];
            best_way_ff  <= way_ff;
            best_tag_ff  <= tag_q_ff;
         end
      end
      if (load_rsp) begin
         rsp_user_ff <= hit_ff;
         rsp_data_ff <= {
            5'b0,
            miss_cnt_in,
            hit_cnt_in,
            evict ? 32'(best_tag_ff) : 32'b0,
            evict,
            salc_pkg::WAYOUT_W'(chosen)
         };
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (state_ff == salc_pkg::ST_META) begin
         meta_q_ff <= meta_mem[set_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[LINE_W'(LINE_W'(set_ff) * LINE_W'(WAYS) + LINE_W'(chosen))] <= addr_ff;
      end
      if (state_ff == salc_pkg::ST_TAG_RD) begin
         tag_q_ff <= tag_mem[line_idx];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

[rtl/core/salc_rem.sv]
`default_nettype none
module salc_rem #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = STEP_W'(DIVIDEND_W);
         shift_in = dividend;
         den_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         step_in  = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire
